[sv/ssndl_pkg.sv]
// Shared types, constants and the segment table for the seven-segment link unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package ssndl_pkg;

    localparam int DIGITS = 4;

    // Request codes carried on the slave tuser
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Command bytes
    localparam logic [7:0] CMD_DATA = 8'h40;
    localparam logic [7:0] CMD_ADDR = 8'hC0;
    localparam logic [7:0] CMD_CTRL = 8'h80;
    localparam logic [7:0] CTRL_ON  = 8'h08;

    // Segment patterns
    localparam logic [7:0] SEG_DOT   = 8'h80;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_ZERO  = 8'h3F;

    // Display range and divide-by-ten reciprocal (exact for values below 43690)
    localparam logic signed [14:0] NUM_MAX     = 15'sd9999;
    localparam logic signed [14:0] NUM_MIN     = -15'sd999;
    localparam logic [15:0]        RECIP_TEN   = 16'd52429;
    localparam int                 RECIP_SHIFT = 19;

    typedef logic [DIGITS-1:0][7:0] t_digits;

    typedef enum logic [11:0] {
        PH_IDLE         = 12'b0000_0000_0001,
        PH_START        = 12'b0000_0000_0010,
        PH_BIT_LOW      = 12'b0000_0000_0100,
        PH_BIT_DATA     = 12'b0000_0000_1000,
        PH_BIT_HIGH     = 12'b0000_0001_0000,
        PH_ACK_REL      = 12'b0000_0010_0000,
        PH_ACK_SAMPLE   = 12'b0000_0100_0000,
        PH_ACK_END      = 12'b0000_1000_0000,
        PH_ACK_END_FAIL = 12'b0001_0000_0000,
        PH_STOP_LOW     = 12'b0010_0000_0000,
        PH_STOP_CLK     = 12'b0100_0000_0000,
        PH_STOP_HIGH    = 12'b1000_0000_0000
    } t_phase;

    function automatic logic [7:0] seg_pattern(input logic [3:0] d);
        logic [7:0] p;
        unique case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[sv/ssndl_fmt.sv]
// Number formatter: saturates a signed value, splits it into decimal digits one per
// cycle and builds the four segment patterns. Depends on ssndl_pkg.
`default_nettype none

module ssndl_fmt
    import ssndl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire logic               i_clear,
    input  wire logic signed [14:0] i_number,
    input  wire logic               i_colon,
    input  wire logic               i_lz,
    output t_digits                 o_digits
);

    logic signed [14:0] v_sat;
    logic               v_neg;
    logic signed [14:0] v_abs;

    logic [13:0] r_mag;
    logic [13:0] r_rem;
    logic        r_neg;
    logic        r_colon;
    logic        r_lz;
    logic        r_run;
    logic [2:0]  r_step;
    logic [DIGITS-1:0][3:0] r_dec;
    t_digits     r_digits;

    logic [29:0] prod;
    logic [13:0] quot;
    logic [13:0] rem_digit;
    logic [1:0]  dec_idx;
    logic [2:0]  n_sig;
    logic [1:0]  minus_idx;
    t_digits     fmt;

    // Saturate and take the magnitude on the request beat
    always_comb begin
        if (i_number > NUM_MAX) begin
            v_sat = NUM_MAX;
        end else if (i_number < NUM_MIN) begin
            v_sat = NUM_MIN;
        end else begin
            v_sat = i_number;
        end
        v_neg = v_sat[14];
        v_abs = v_neg ? -v_sat : v_sat;
    end

    // One divide-by-ten per cycle, ones digit first
    assign prod      = r_rem * RECIP_TEN;
    assign quot      = 14'(prod[29:RECIP_SHIFT]);
    assign rem_digit = r_rem - ((quot << 3) + (quot << 1));
    assign dec_idx   = 2'(DIGITS - 1) - r_step[1:0];

    always_comb begin
        if (r_mag >= 14'd1000) begin
            n_sig = 3'd4;
        end else if (r_mag >= 14'd100) begin
            n_sig = 3'd3;
        end else if (r_mag >= 14'd10) begin
            n_sig = 3'd2;
        end else begin
            n_sig = 3'd1;
        end
        minus_idx = r_lz ? 2'd0 : 2'(3'(DIGITS - 1) - n_sig);
        for (int p = 0; p < DIGITS; p++) begin
            if (3'(DIGITS - 1 - p) < n_sig) begin
                fmt[p] = seg_pattern(r_dec[p]);
            end else if (r_neg && (2'(p) == minus_idx)) begin
                fmt[p] = SEG_MINUS;
            end else if (r_lz) begin
                fmt[p] = SEG_ZERO;
            end else begin
                fmt[p] = 8'h00;
            end
        end
        if (r_colon) begin
            fmt[DIGITS/2-1] = fmt[DIGITS/2-1] | SEG_DOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_step   <= '0;
            r_digits <= '0;
        end else if (i_clear) begin
            r_run    <= 1'b0;
            r_digits <= '0;
        end else if (i_load) begin
            r_run  <= 1'b1;
            r_step <= '0;
        end else if (r_run) begin
            if (r_step == 3'(DIGITS)) begin
                r_digits <= fmt;
                r_run    <= 1'b0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mag   <= v_abs[13:0];
            r_rem   <= v_abs[13:0];
            r_neg   <= v_neg;
            r_colon <= i_colon;
            r_lz    <= i_lz;
        end else if (r_run && (r_step != 3'(DIGITS))) begin
            r_dec[dec_idx] <= rem_digit[3:0];
            r_rem          <= quot;
        end
    end

    assign o_digits = r_digits;

endmodule

`default_nettype wire

[sv/seven_segment_number_display_link_unit.sv]
// Two-wire seven-segment display link: tick-driven frame sequencer with output skid.
// Depends on ssndl_pkg and ssndl_fmt.
//
// Usage: each slave beat is one bit-delay tick. tuser carries the request code
// (tick only, write number, clear display); a write or clear taken while idle
// starts a transfer of three frames: data command, address command plus four
// digit patterns, and display control with the brightness. Every tick yields
// exactly one master beat with the pin levels to drive and busy/done/failed.
// The acknowledge level is read from dio_in on the sampling tick.
// Each tick's beat is registered in the output register or in the skid entry.
// Throughput: one tick per cycle while s_axis_tready is high; the step logic is
// single pass from state. The digit patterns are built by a divide-by-ten unit after
// the request, far ahead of the first digit bit on the wire.
// Reset: idle, pins low and driven, digits blank, brightness 0.
// Stall: a two-entry output stage holds beats while m_axis_tready is low;
// s_axis_tready drops only when both entries are full.
`default_nettype none

module seven_segment_number_display_link_unit
    import ssndl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [14:0] number, [17:15] brightness, [18] colon, [19] zero_fill, [20] dio_in
    input  wire logic [23:0] s_axis_tdata,
    // [1:0] operation
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] clk_level, [1] dio_level, [2] dio_released, [3] busy_res, [4] done_res,
    // [5] failed
    output logic [7:0]       m_axis_tdata
);

    logic        tick;
    logic [1:0]  op;
    logic        in_dio;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_frame, n_frame;
    logic [2:0]  r_byte,  n_byte;
    logic [2:0]  r_bit,   n_bit;
    logic [2:0]  r_level, n_level;
    logic        r_pin_clk, n_pin_clk;
    logic        r_pin_dio, n_pin_dio;
    logic        r_pin_rel, n_pin_rel;

    logic        busy, done, fail;
    logic        fmt_load, fmt_clear;
    t_digits     digits;
    logic [7:0]  cur_byte;
    logic [1:0]  dig_idx;
    logic [7:0]  item;

    logic        r_out_valid, r_skid_valid;
    logic [7:0]  r_out_data,  r_skid_data;
    logic        pop;

    assign tick   = s_axis_tvalid && s_axis_tready;
    assign op     = s_axis_tuser;
    assign in_dio = s_axis_tdata[20];

    ssndl_fmt u_fmt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fmt_load),
        .i_clear  (fmt_clear),
        .i_number (s_axis_tdata[14:0]),
        .i_colon  (s_axis_tdata[18]),
        .i_lz     (s_axis_tdata[19]),
        .o_digits (digits)
    );

    assign dig_idx = 2'(r_byte - 3'd1);

    always_comb begin
        if (r_frame == 2'd0) begin
            cur_byte = CMD_DATA;
        end else if (r_frame == 2'd1) begin
            if (r_byte == 3'd0 || r_byte > 3'(DIGITS)) begin
                cur_byte = CMD_ADDR;
            end else begin
                cur_byte = digits[dig_idx];
            end
        end else begin
            cur_byte = CMD_CTRL | CTRL_ON | {5'd0, r_level};
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_frame   = r_frame;
        n_byte    = r_byte;
        n_bit     = r_bit;
        n_level   = r_level;
        n_pin_clk = r_pin_clk;
        n_pin_dio = r_pin_dio;
        n_pin_rel = r_pin_rel;
        busy      = 1'b1;
        done      = 1'b0;
        fail      = 1'b0;
        fmt_load  = 1'b0;
        fmt_clear = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (op == OP_WRITE || op == OP_CLEAR) begin
                fmt_load  = tick && (op == OP_WRITE);
                fmt_clear = tick && (op == OP_CLEAR);
                n_level   = (op == OP_WRITE) ? s_axis_tdata[17:15] : 3'd0;
                n_frame   = 2'd0;
                n_byte    = 3'd0;
                n_bit     = 3'd0;
                n_phase   = PH_START;
            end else begin
                busy = 1'b0;
            end
        end

        if (busy) begin
            unique case (n_phase)
                PH_START: begin
                    n_pin_dio = 1'b0;
                    n_pin_rel = 1'b0;
                    n_bit     = 3'd0;
                    n_phase   = PH_BIT_LOW;
                end
                PH_BIT_LOW: begin
                    n_pin_clk = 1'b0;
                    n_phase   = PH_BIT_DATA;
                end
                PH_BIT_DATA: begin
                    n_pin_dio = cur_byte[r_bit];
                    n_phase   = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: begin
                    n_pin_clk = 1'b1;
                    n_bit     = r_bit + 3'd1;
                    n_phase   = (r_bit == 3'd7) ? PH_ACK_REL : PH_BIT_LOW;
                end
                PH_ACK_REL: begin
                    n_pin_clk = 1'b0;
                    n_pin_dio = 1'b1;
                    n_pin_rel = 1'b1;
                    n_phase   = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE: begin
                    n_pin_clk = 1'b1;
                    n_phase   = in_dio ? PH_ACK_END_FAIL : PH_ACK_END;
                end
                PH_ACK_END: begin
                    n_pin_clk = 1'b0;
                    n_pin_dio = 1'b0;
                    n_pin_rel = 1'b0;
                    if (r_frame == 2'd1 && r_byte < 3'(DIGITS)) begin
                        n_byte  = r_byte + 3'd1;
                        n_bit   = 3'd0;
                        n_phase = PH_BIT_LOW;
                    end else begin
                        n_phase = PH_STOP_LOW;
                    end
                end
                PH_ACK_END_FAIL: begin
                    n_pin_clk = 1'b0;
                    n_pin_dio = 1'b0;
                    n_pin_rel = 1'b0;
                    n_phase   = PH_IDLE;
                    busy      = 1'b0;
                    done      = 1'b1;
                    fail      = 1'b1;
                end
                PH_STOP_LOW: begin
                    n_pin_dio = 1'b0;
                    n_pin_rel = 1'b0;
                    n_phase   = PH_STOP_CLK;
                end
                PH_STOP_CLK: begin
                    n_pin_clk = 1'b1;
                    n_phase   = PH_STOP_HIGH;
                end
                PH_STOP_HIGH: begin
                    n_pin_dio = 1'b1;
                    if (r_frame < 2'd2) begin
                        n_frame = r_frame + 2'd1;
                        n_byte  = 3'd0;
                        n_phase = PH_START;
                    end else begin
                        n_phase = PH_IDLE;
                        busy    = 1'b0;
                        done    = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    busy    = 1'b0;
                end
            endcase
        end
    end

    assign item = {2'b00, fail, done, busy, n_pin_rel, n_pin_dio, n_pin_clk};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_frame   <= '0;
            r_byte    <= '0;
            r_bit     <= '0;
            r_level   <= '0;
            r_pin_clk <= 1'b0;
            r_pin_dio <= 1'b0;
            r_pin_rel <= 1'b0;
        end else if (tick) begin
            r_phase   <= n_phase;
            r_frame   <= n_frame;
            r_byte    <= n_byte;
            r_bit     <= n_bit;
            r_level   <= n_level;
            r_pin_clk <= n_pin_clk;
            r_pin_dio <= n_pin_dio;
            r_pin_rel <= n_pin_rel;
        end
    end

    // Output register with one skid entry behind it
    assign pop           = r_out_valid && m_axis_tready;
    assign s_axis_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= tick;
            end
        end else if (tick) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_data <= r_skid_valid ? r_skid_data : item;
        end else if (tick && !r_out_valid) begin
            r_out_data <= item;
        end
        if (tick && r_out_valid && !pop) begin
            r_skid_data <= item;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

[test/seven_segment_number_display_link_unit_test.sv]
// Self-checking bench for the seven-segment display link unit: random and directed ticks
// with requests, a tick-exact line-level predictor and a beat-by-beat output check.
// Depends on ssndl_pkg and the seven_segment_number_display_link_unit RTL.
module seven_segment_number_display_link_unit_test;
    import ssndl_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_TICKS = 150;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int NO_NACK = -1;
    // segment pattern for each decimal digit, index 0 = digit 0
    localparam logic [9:0][7:0] DIGIT_SEGS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                              8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

    typedef struct packed {
        logic [1:0]  op;
        logic [14:0] number;
        logic [2:0]  level;
        logic        colon;
        logic        lz;
        logic        dio_in;
    } t_tick;

    typedef struct packed {
        t_tick tick;
        logic  drain_first;
    } t_pending_tick;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic dio_released;
        logic busy;
        logic done;
        logic failed;
    } t_line_beat;

    typedef struct packed {
        t_digits    digits;
        logic [2:0] level;
        logic [1:0] frame;
        logic [2:0] byte_pos;
        logic [2:0] bit_pos;
        t_phase     phase;
        logic       clk;
        logic       dio;
        logic       rel;
    } t_link_state;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    t_pending_tick pending_ticks[$];
    t_line_beat    expected_beats[$];
    t_link_state   gen_state;
    t_link_state   line_state;
    logic          hold_next = 1'b0;
    int            n_generated = 0;
    int            n_accepted = 0;
    int            n_checked = 0;
    int            n_errors = 0;
    int            burst_left = 0;
    int            gap_left = 0;
    int            ready_mode = 0;
    int            ready_left = 0;
    int            quiet_cycles = 0;

    seven_segment_number_display_link_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_link_state idle_link();
        t_link_state s;
        s = '0;
        s.phase = PH_IDLE;
        return s;
    endfunction

    function automatic t_digits format_number(input logic [14:0] raw, input logic lz,
                                              input logic colon);
        t_digits d;
        int      v;
        int      pos;
        bit      neg;
        d = '0;
        v = $signed(raw);
        if (v > 9999) v = 9999;
        if (v < -999) v = -999;
        neg = (v < 0);
        if (neg) v = -v;
        pos = DIGITS - 1;
        if (v == 0) begin
            d[DIGITS-1] = SEG_ZERO;
        end else begin
            while (v != 0) begin
                d[pos] = DIGIT_SEGS[v % 10];
                v = v / 10;
                pos--;
            end
            if (neg) d[lz ? 0 : pos] = SEG_MINUS;
        end
        if (lz) begin
            for (int k = 0; k < DIGITS; k++)
                if (d[k] == 8'h00) d[k] = SEG_ZERO;
        end
        if (colon) d[DIGITS/2-1] = d[DIGITS/2-1] | SEG_DOT;
        return d;
    endfunction

    function automatic logic [7:0] wire_byte(input t_link_state s);
        if (s.frame == 2'd0) return CMD_DATA;
        if (s.frame == 2'd1) begin
            if (s.byte_pos == 3'd0 || s.byte_pos > DIGITS) return CMD_ADDR;
            return s.digits[s.byte_pos - 1];
        end
        return CMD_CTRL | CTRL_ON | {5'b00000, s.level};
    endfunction

    // Advance the line model by one tick and return the beat it produces.
    task automatic step_link(inout t_link_state s, input t_tick t, output t_line_beat r);
        logic busy;
        logic done;
        logic failed;
        logic [7:0] b;
        busy = 1'b1;
        done = 1'b0;
        failed = 1'b0;
        if (s.phase == PH_IDLE) begin
            if (t.op == OP_WRITE || t.op == OP_CLEAR) begin
                if (t.op == OP_WRITE) begin
                    s.digits = format_number(t.number, t.lz, t.colon);
                    s.level = t.level;
                end else begin
                    s.digits = '0;
                    s.level = '0;
                end
                s.frame = '0;
                s.byte_pos = '0;
                s.bit_pos = '0;
                s.phase = PH_START;
            end else begin
                busy = 1'b0;
            end
        end
        if (busy) begin
            case (s.phase)
                PH_START: begin
                    s.dio = 1'b0;
                    s.rel = 1'b0;
                    s.bit_pos = '0;
                    s.phase = PH_BIT_LOW;
                end
                PH_BIT_LOW: begin
                    s.clk = 1'b0;
                    s.phase = PH_BIT_DATA;
                end
                PH_BIT_DATA: begin
                    b = wire_byte(s);
                    s.dio = b[s.bit_pos];
                    s.phase = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: begin
                    s.clk = 1'b1;
                    s.bit_pos = s.bit_pos + 3'd1;
                    s.phase = (s.bit_pos == 3'd0) ? PH_ACK_REL : PH_BIT_LOW;
                end
                PH_ACK_REL: begin
                    s.clk = 1'b0;
                    s.dio = 1'b1;
                    s.rel = 1'b1;
                    s.phase = PH_ACK_SAMPLE;
                end
                PH_ACK_SAMPLE: begin
                    s.clk = 1'b1;
                    s.phase = t.dio_in ? PH_ACK_END_FAIL : PH_ACK_END;
                end
                PH_ACK_END: begin
                    s.clk = 1'b0;
                    s.dio = 1'b0;
                    s.rel = 1'b0;
                    if (s.frame == 2'd1 && s.byte_pos < DIGITS) begin
                        s.byte_pos = s.byte_pos + 3'd1;
                        s.bit_pos = '0;
                        s.phase = PH_BIT_LOW;
                    end else begin
                        s.phase = PH_STOP_LOW;
                    end
                end
                PH_ACK_END_FAIL: begin
                    s.clk = 1'b0;
                    s.dio = 1'b0;
                    s.rel = 1'b0;
                    s.phase = PH_IDLE;
                    busy = 1'b0;
                    done = 1'b1;
                    failed = 1'b1;
                end
                PH_STOP_LOW: begin
                    s.dio = 1'b0;
                    s.rel = 1'b0;
                    s.phase = PH_STOP_CLK;
                end
                PH_STOP_CLK: begin
                    s.clk = 1'b1;
                    s.phase = PH_STOP_HIGH;
                end
                PH_STOP_HIGH: begin
                    s.dio = 1'b1;
                    if (s.frame < 2'd2) begin
                        s.frame = s.frame + 2'd1;
                        s.byte_pos = '0;
                        s.phase = PH_START;
                    end else begin
                        s.phase = PH_IDLE;
                        busy = 1'b0;
                        done = 1'b1;
                    end
                end
                default: begin
                    s.phase = PH_IDLE;
                    busy = 1'b0;
                end
            endcase
        end
        r.clk_level = s.clk;
        r.dio_level = s.dio;
        r.dio_released = s.rel;
        r.busy = busy;
        r.done = done;
        r.failed = failed;
    endtask

    function automatic t_tick random_tick();
        t_tick t;
        t.op = 2'($urandom_range(0, 3));
        t.number = 15'($urandom_range(0, 32767));
        t.level = 3'($urandom_range(0, 7));
        t.colon = 1'($urandom_range(0, 1));
        t.lz = 1'($urandom_range(0, 1));
        t.dio_in = 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic int pick_number();
        case ($urandom_range(0, 3))
            0: return $signed(15'($urandom_range(0, 32767)));
            1: return int'($urandom_range(0, 10998)) - 999;
            2: return int'($urandom_range(0, 198)) - 99;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 9999;
                    1: return -999;
                    2: return 0;
                    3: return 16383;
                    4: return -16384;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // Queue one tick for the driver; the generator's own copy of the line model
    // tells where the transfer stands.
    task automatic queue_tick(input t_tick t, output t_line_beat r);
        t_pending_tick p;
        step_link(gen_state, t, r);
        p.tick = t;
        p.drain_first = hold_next;
        hold_next = 1'b0;
        pending_ticks.push_back(p);
        n_generated++;
    endtask

    task automatic idle_tick(input logic [1:0] op, input int value, input logic fill);
        t_tick t;
        t_line_beat r;
        t = '{op: op, number: 15'(value), level: {3{fill}}, colon: fill, lz: fill,
              dio_in: fill};
        queue_tick(t, r);
    endtask

    task automatic run_transfer(input logic [1:0] op, input int value, input logic [2:0] lvl,
                                input logic colon, input logic lz, input int nack_at,
                                input bit noisy);
        t_tick      t;
        t_line_beat r;
        int         acks;
        acks = 0;
        t = random_tick();
        t.op = op;
        t.number = 15'(value);
        t.level = lvl;
        t.colon = colon;
        t.lz = lz;
        queue_tick(t, r);
        do begin
            t = random_tick();
            t.op = (noisy && $urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : OP_TICK;
            if (gen_state.phase == PH_ACK_SAMPLE) begin
                t.dio_in = (acks == nack_at);
                acks++;
            end
            queue_tick(t, r);
        end while (!r.done);
    endtask

    task automatic check_field(input string name, input logic exp, input logic act);
        if (exp !== act) begin
            n_errors++;
            $error("%s: expected %0b, got %0b", name, exp, act);
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : drive
        int acc;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            acc = n_accepted;
            if (s_axis_tvalid && s_axis_tready) begin
                void'(pending_ticks.pop_front());
                acc++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_ticks.size() > 0 &&
                             !(pending_ticks[0].drain_first && n_checked != acc)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {3'b000, pending_ticks[0].tick.dio_in,
                                     pending_ticks[0].tick.lz, pending_ticks[0].tick.colon,
                                     pending_ticks[0].tick.level, pending_ticks[0].tick.number};
                    s_axis_tuser <= pending_ticks[0].tick.op;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 7) == 0) begin
                        burst_left = $urandom_range(100, 400);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches among four modes at random intervals.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (ready_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                ready_left <= $urandom_range(50, 300);
            end else begin
                ready_left <= ready_left - 1;
            end
            case (ready_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Predict on every accepted tick, then check the oldest prediction against the beat out.
    always @(posedge i_clk) begin : observe
        t_tick      t;
        t_line_beat r;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                t.op = s_axis_tuser;
                t.number = s_axis_tdata[14:0];
                t.level = s_axis_tdata[17:15];
                t.colon = s_axis_tdata[18];
                t.lz = s_axis_tdata[19];
                t.dio_in = s_axis_tdata[20];
                step_link(line_state, t, r);
                expected_beats.push_back(r);
                n_accepted <= n_accepted + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    n_errors++;
                    $error("unexpected beat 0x%02h with nothing outstanding", m_axis_tdata);
                end else begin
                    r = expected_beats.pop_front();
                    check_field("clk_level", r.clk_level, m_axis_tdata[0]);
                    check_field("dio_level", r.dio_level, m_axis_tdata[1]);
                    check_field("dio_released", r.dio_released, m_axis_tdata[2]);
                    check_field("busy_res", r.busy, m_axis_tdata[3]);
                    check_field("done_res", r.done, m_axis_tdata[4]);
                    check_field("failed", r.failed, m_axis_tdata[5]);
                    n_checked <= n_checked + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("** seven_segment_number_display_link_unit: FAILED **");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        int start_count;
        int nack_at;
        gen_state = idle_link();
        line_state = idle_link();

        // idle ticks with field extremes, including the unused request code
        idle_tick(OP_UNUSED, -1, 1'b1);
        idle_tick(OP_TICK, 0, 1'b0);
        idle_tick(OP_UNUSED, 16383, 1'b0);
        run_transfer(OP_WRITE, 0, 3'd0, 1'b0, 1'b0, NO_NACK, 1'b0);
        run_transfer(OP_WRITE, 16383, 3'd5, 1'b1, 1'b0, NO_NACK, 1'b0);
        run_transfer(OP_WRITE, -16384, 3'd1, 1'b1, 1'b1, NO_NACK, 1'b0);
        run_transfer(OP_WRITE, -5, 3'd4, 1'b0, 1'b0, NO_NACK, 1'b0);
        run_transfer(OP_CLEAR, 8765, 3'd7, 1'b1, 1'b1, NO_NACK, 1'b0);
        // missing acknowledge on the data command and on a digit
        run_transfer(OP_WRITE, 8, 3'd2, 1'b0, 1'b0, 0, 1'b0);
        run_transfer(OP_WRITE, 3210, 3'd5, 1'b1, 1'b0, 3, 1'b0);
        // requests arriving mid-transfer must be ignored
        run_transfer(OP_WRITE, 5678, 3'd3, 1'b1, 1'b1, NO_NACK, 1'b1);

        hold_next = 1'b1;
        start_count = n_generated;
        while (n_generated - start_count < RANDOM_TICKS) begin
            if ($urandom_range(0, 9) < 8) begin
                nack_at = ($urandom_range(0, 9) < 7) ? NO_NACK : $urandom_range(0, 6);
                if ($urandom_range(0, 9) == 0) hold_next = 1'b1;
                run_transfer(($urandom_range(0, 9) == 0) ? OP_CLEAR : OP_WRITE, pick_number(),
                             3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), nack_at, 1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 10))
                    idle_tick(($urandom_range(0, 1) == 0) ? OP_TICK : OP_UNUSED,
                              pick_number(), 1'($urandom_range(0, 1)));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_ticks.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (n_checked != n_accepted || expected_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && expected_beats.size() == 0) begin
            $display("** seven_segment_number_display_link_unit: PASSED **");
        end else begin
            $display("** seven_segment_number_display_link_unit: FAILED **");
        end
        $finish;
    end

endmodule
